@@ src/pwcr_pkg.sv @@
// Shared types and constants of the pulse-width command relay filter.
package pwcr_pkg;

    localparam int NBITS = 8;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MAX_FRAME   = 3'd0;
    localparam logic [2:0] CFG_LEAD        = 3'd1;
    localparam logic [2:0] CFG_LONG        = 3'd2;
    localparam logic [2:0] CFG_SHORT       = 3'd3;
    localparam logic [2:0] CFG_HOLD        = 3'd4;
    localparam logic [2:0] CFG_ACTIVE_LOW  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [7:0] MAX_FRAME_RESET = 8'd110;
    localparam logic [7:0] LEAD_RESET      = 8'd20;
    localparam logic [7:0] LONG_RESET      = 8'd7;
    localparam logic [7:0] SHORT_RESET     = 8'd3;
    localparam logic [7:0] HOLD_RESET      = 8'd80;
    localparam logic       ACTIVE_LOW_RESET = 1'b1;

    // Byte fields touched by the filter.
    localparam logic [7:0] KEEP_BITS     = 8'hF1;
    localparam logic [1:0] FAN_CODE_FULL = 2'b11;
    localparam logic [1:0] FAN_CODE_HIGH = 2'b10;

    typedef struct packed {
        logic       done;
        logic       timeout;
        logic [7:0] data;
    } rx_result_t;

    typedef struct packed {
        logic [7:0] lead_len;
        logic [7:0] long_len;
        logic [7:0] short_len;
    } tx_cfg_t;

endpackage

@@ src/pulse_width_command_relay_filter.sv @@
// Top level of the pulse-width command relay with dead-band filter.
//
// Each input transaction carries one oversampled level of the input line
// (line_in). The block decodes 8-bit pulse-width frames, MSB first, filters
// every received byte (a fan field of both bits becomes high, and a changed
// pump or fan field is locked for hold_frames later frames) and re-encodes
// the filtered byte on line_out.
// Every input transaction yields exactly one output transaction holding the
// output line level, the frame done and timeout flags, the last received
// byte and the byte being sent.
// The state update for a tick happens at the edge that accepts it, and its
// result sits in the output register from then on. One tick is taken per
// cycle unless a result is stalled; the receiver, filter and transmitter
// updates form one short path between the state and the result register.
// When the receiver stalls, the result register holds and in_ready stays
// high only in the cycle the held result is taken, so no result is lost.
// Reset clears all state and loads the configuration defaults, leaving no
// result pending. The user must write configuration via cfg_write, cfg_index
// and cfg_data, one register per cycle, only while idle; it is unchecked.
module pulse_width_command_relay_filter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       line_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       line_out,
    output logic       frame_done,
    output logic       frame_timeout,
    output logic [7:0] received_byte,
    output logic [7:0] sent_byte
);
    import pwcr_pkg::*;

    // Configuration registers.
    logic [7:0] max_frame_reg;
    logic [7:0] lead_reg;
    logic [7:0] long_reg;
    logic [7:0] short_reg;
    logic [7:0] hold_reg;
    logic       active_low_reg;

    // Filter state.
    logic       first_frame_reg;
    logic       pump_prev_reg, pump_prev_next;
    logic [1:0] fan_prev_reg, fan_prev_next;
    logic [7:0] pump_lock_reg, pump_lock_next;
    logic [7:0] fan_lock_reg, fan_lock_next;
    logic [7:0] last_rx_reg;

    // Result register.
    logic       out_valid_reg;
    logic       line_out_reg;
    logic       frame_done_reg;
    logic       frame_timeout_reg;
    logic [7:0] received_byte_reg;
    logic [7:0] sent_byte_reg;

    logic       accept;
    logic       act;
    rx_result_t rx_res;
    tx_cfg_t    tx_cfg;
    logic [7:0] filtered_byte;
    logic       tx_active_next;
    logic [7:0] tx_byte_next;
    logic [7:0] last_rx_next;

    // A new tick is taken whenever the result register is empty or is being
    // emptied in the same cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign act      = line_in ^ active_low_reg;

    assign tx_cfg.lead_len  = lead_reg;
    assign tx_cfg.long_len  = long_reg;
    assign tx_cfg.short_len = short_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg  <= MAX_FRAME_RESET;
            lead_reg       <= LEAD_RESET;
            long_reg       <= LONG_RESET;
            short_reg      <= SHORT_RESET;
            hold_reg       <= HOLD_RESET;
            active_low_reg <= ACTIVE_LOW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_FRAME:  max_frame_reg  <= cfg_data;
                CFG_LEAD:       lead_reg       <= cfg_data;
                CFG_LONG:       long_reg       <= cfg_data;
                CFG_SHORT:      short_reg      <= cfg_data;
                CFG_HOLD:       hold_reg       <= cfg_data;
                CFG_ACTIVE_LOW: active_low_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    pwcr_rx u_rx (
        .clk             (clk),
        .rst_n           (rst_n),
        .enable          (accept),
        .act             (act),
        .max_frame_ticks (max_frame_reg),
        .result          (rx_res)
    );

    // Dead-band filter. On the first byte the current fields become the
    // previous values with both locks clear, so nothing is locked by it.
    always_comb
    begin
        logic       pump;
        logic [1:0] fan;
        logic       pp;
        logic [1:0] fp;
        logic [7:0] pl;
        logic [7:0] fl;
        pump = rx_res.data[1];
        fan  = rx_res.data[3:2];
        if (fan == FAN_CODE_FULL)
            fan = FAN_CODE_HIGH;
        pp = first_frame_reg ? pump : pump_prev_reg;
        fp = first_frame_reg ? fan : fan_prev_reg;
        pl = first_frame_reg ? 8'd0 : pump_lock_reg;
        fl = first_frame_reg ? 8'd0 : fan_lock_reg;
        if (pl != 8'd0)
        begin
            pump = pp;
            pl   = pl - 8'd1;
        end
        if (fl != 8'd0)
        begin
            fan = fp;
            fl  = fl - 8'd1;
        end
        if (pump != pp)
        begin
            pp = pump;
            pl = hold_reg;
        end
        if (fan != fp)
        begin
            fp = fan;
            fl = hold_reg;
        end
        pump_prev_next = pp;
        fan_prev_next  = fp;
        pump_lock_next = pl;
        fan_lock_next  = fl;
        filtered_byte  = (rx_res.data & KEEP_BITS) | {4'd0, fan, pump, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_frame_reg <= 1'b1;
            pump_prev_reg   <= 1'b0;
            fan_prev_reg    <= 2'd0;
            pump_lock_reg   <= 8'd0;
            fan_lock_reg    <= 8'd0;
            last_rx_reg     <= 8'd0;
        end
        else if (accept && rx_res.done)
        begin
            first_frame_reg <= 1'b0;
            pump_prev_reg   <= pump_prev_next;
            fan_prev_reg    <= fan_prev_next;
            pump_lock_reg   <= pump_lock_next;
            fan_lock_reg    <= fan_lock_next;
            last_rx_reg     <= rx_res.data;
        end
    end

    pwcr_tx u_tx (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (accept),
        .start       (rx_res.done),
        .start_byte  (filtered_byte),
        .cfg         (tx_cfg),
        .active_next (tx_active_next),
        .byte_next   (tx_byte_next)
    );

    assign last_rx_next = rx_res.done ? rx_res.data : last_rx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_out_reg      <= tx_active_next ^ active_low_reg;
            frame_done_reg    <= rx_res.done;
            frame_timeout_reg <= rx_res.timeout;
            received_byte_reg <= last_rx_next;
            sent_byte_reg     <= tx_byte_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign line_out      = line_out_reg;
    assign frame_done    = frame_done_reg;
    assign frame_timeout = frame_timeout_reg;
    assign received_byte = received_byte_reg;
    assign sent_byte     = sent_byte_reg;

    // A tick either finishes a frame or drops it, never both.
    a_done_xor_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_done && frame_timeout))
        else $error("frame done and timeout reported together");

    // The filter never lets the fan field carry both bits.
    a_fan_filtered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sent_byte[3:2] != FAN_CODE_FULL)
        else $error("sent byte carries an unfiltered fan field");

    // On a finished frame the bits outside pump and fan pass unchanged.
    a_keep_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (sent_byte & KEEP_BITS) == (received_byte & KEEP_BITS))
        else $error("filter altered bits it must keep");

    // A stalled result must be held until it is taken.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sent_byte) && $stable(line_out)))
        else $error("pending result changed while stalled");

endmodule

@@ src/pwcr_rx.sv @@
// Pulse-width frame receiver with frame timeout.
module pwcr_rx (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  logic               act,
    input  logic [7:0]         max_frame_ticks,
    output pwcr_pkg::rx_result_t result
);
    import pwcr_pkg::*;

    typedef enum logic [1:0] {
        RX_IDLE  = 2'd0,
        RX_LEAD  = 2'd1,
        RX_INACT = 2'd2,
        RX_ACT   = 2'd3
    } rx_state_t;

    rx_state_t  state_reg, state_next;
    logic [7:0] ticks_reg, ticks_next;
    logic [3:0] idx_reg, idx_next;
    logic [7:0] inact_reg, inact_next;
    logic [7:0] act_reg, act_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] ticks_inc;

    assign ticks_inc = (ticks_reg == 8'hFF) ? ticks_reg : ticks_reg + 8'd1;

    always_comb
    begin
        state_next     = state_reg;
        ticks_next     = ticks_reg;
        idx_next       = idx_reg;
        inact_next     = inact_reg;
        act_next       = act_reg;
        shift_next     = shift_reg;
        result.done    = 1'b0;
        result.timeout = 1'b0;
        if (state_reg == RX_IDLE)
        begin
            if (act)
            begin
                state_next = RX_LEAD;
                ticks_next = 8'd1;
                idx_next   = 4'd0;
                shift_next = 8'd0;
            end
        end
        else
        begin
            ticks_next = ticks_inc;
            if (ticks_inc > max_frame_ticks && max_frame_ticks != 8'hFF)
            begin
                state_next     = RX_IDLE;
                result.timeout = 1'b1;
            end
            else
            begin
                case (state_reg)
                    RX_LEAD:
                    begin
                        if (!act)
                        begin
                            state_next = RX_INACT;
                            inact_next = 8'd0;
                            act_next   = 8'd0;
                        end
                    end
                    RX_INACT:
                    begin
                        if (act)
                            state_next = RX_ACT;
                        else if (inact_reg != 8'hFF)
                            inact_next = inact_reg + 8'd1;
                    end
                    RX_ACT:
                    begin
                        if (act)
                        begin
                            if (act_reg != 8'hFF)
                                act_next = act_reg + 8'd1;
                        end
                        else
                        begin
                            if (inact_reg > act_reg && idx_reg < 4'(NBITS))
                                shift_next[~idx_reg[2:0]] = 1'b1;
                            idx_next = idx_reg + 4'd1;
                            if (idx_next >= 4'(NBITS))
                            begin
                                state_next  = RX_IDLE;
                                result.done = 1'b1;
                            end
                            else
                            begin
                                state_next = RX_INACT;
                                inact_next = 8'd0;
                                act_next   = 8'd0;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = RX_IDLE;
                    end
                endcase
            end
        end
        result.data = shift_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RX_IDLE;
            ticks_reg <= 8'd0;
            idx_reg   <= 4'd0;
            inact_reg <= 8'd0;
            act_reg   <= 8'd0;
            shift_reg <= 8'd0;
        end
        else if (enable)
        begin
            state_reg <= state_next;
            ticks_reg <= ticks_next;
            idx_reg   <= idx_next;
            inact_reg <= inact_next;
            act_reg   <= act_next;
            shift_reg <= shift_next;
        end
    end

endmodule

@@ src/pwcr_tx.sv @@
// Pulse-width frame transmitter.
module pwcr_tx (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  logic              start,
    input  logic [7:0]        start_byte,
    input  pwcr_pkg::tx_cfg_t cfg,
    output logic              active_next,
    output logic [7:0]        byte_next
);
    import pwcr_pkg::*;

    typedef enum logic [1:0] {
        TX_IDLE  = 2'd0,
        TX_INACT = 2'd2,
        TX_ACT   = 2'd3
    } tx_state_t;

    tx_state_t  state_reg, state_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [3:0] idx_reg, idx_next;
    logic [7:0] byte_reg;
    logic       active_reg;
    logic       bit_one;

    assign bit_one = (idx_reg < 4'(NBITS)) && byte_reg[~idx_reg[2:0]];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        byte_next   = byte_reg;
        active_next = active_reg;
        if (start)
        begin
            // A new byte restarts sending at once with a fresh lead pulse.
            byte_next   = start_byte;
            cnt_next    = cfg.lead_len;
            idx_next    = 4'd0;
            state_next  = TX_ACT;
            active_next = 1'b1;
        end
        else
        begin
            case (state_reg)
                TX_IDLE:
                begin
                end
                TX_INACT:
                begin
                    if (cnt_reg > 8'd1)
                        cnt_next = cnt_reg - 8'd1;
                    else
                    begin
                        cnt_next    = bit_one ? cfg.short_len : cfg.long_len;
                        idx_next    = idx_reg + 4'd1;
                        active_next = 1'b1;
                        state_next  = TX_ACT;
                    end
                end
                TX_ACT:
                begin
                    if (cnt_reg > 8'd1)
                        cnt_next = cnt_reg - 8'd1;
                    else if (idx_reg >= 4'(NBITS))
                    begin
                        active_next = 1'b0;
                        state_next  = TX_IDLE;
                    end
                    else
                    begin
                        cnt_next    = bit_one ? cfg.long_len : cfg.short_len;
                        active_next = 1'b0;
                        state_next  = TX_INACT;
                    end
                end
                default:
                begin
                    state_next = TX_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TX_IDLE;
            cnt_reg    <= 8'd0;
            idx_reg    <= 4'd0;
            byte_reg   <= 8'd0;
            active_reg <= 1'b0;
        end
        else if (enable)
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            byte_reg   <= byte_next;
            active_reg <= active_next;
        end
    end

endmodule
